FILE: hw/rtl/fair_share_vruntime_scheduler_unit_defines.svh
// Assertion macros used by the checker.
`ifndef FAIR_SHARE_VRUNTIME_SCHEDULER_UNIT_DEFINES_SVH
`define FAIR_SHARE_VRUNTIME_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FSVS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsvs check failed");

// Next-cycle implication, disabled while reset is high.
`define FSVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsvs check failed");

`endif

FILE: hw/rtl/fsvs_pkg.sv
// ----------------------------------------------------------------------------
// fsvs_pkg
// Types, codes and the nice-to-weight table of the fair-share scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fsvs_pkg;

  localparam int PROC_SLOTS_DEF = 64;
  localparam logic [15:0] MAX_SLICE_RST = 16'd5;
  localparam logic [33:0] CHARGE_BASE = 34'd1048576;
  localparam logic [22:0] WEIGHT_SUM_MAX = 23'h7FFFFF;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PICK = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_TICK_WR,
    S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_PICK_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic               queued;
    logic signed [5:0]  nice;
    logic [15:0]        slice;
    logic [63:0]        vr;
  } entry_t;

  function automatic logic signed [5:0] clamp_nice(input logic signed [5:0] n);
    if (n < -6'sd20) return -6'sd20;
    else if (n > 6'sd19) return 6'sd19;
    else return n;
  endfunction

  function automatic logic [16:0] weight_of(input logic signed [5:0] n);
    logic [5:0] k;
    k = n + 6'sd20;
    case (k)
      6'd0:  return 17'd88761;  6'd1:  return 17'd71755;
      6'd2:  return 17'd56483;  6'd3:  return 17'd46273;
      6'd4:  return 17'd36291;  6'd5:  return 17'd29154;
      6'd6:  return 17'd23254;  6'd7:  return 17'd18705;
      6'd8:  return 17'd14949;  6'd9:  return 17'd11916;
      6'd10: return 17'd9548;   6'd11: return 17'd7620;
      6'd12: return 17'd6100;   6'd13: return 17'd4904;
      6'd14: return 17'd3906;   6'd15: return 17'd3121;
      6'd16: return 17'd2501;   6'd17: return 17'd1991;
      6'd18: return 17'd1586;   6'd19: return 17'd1277;
      6'd20: return 17'd1024;   6'd21: return 17'd820;
      6'd22: return 17'd655;    6'd23: return 17'd526;
      6'd24: return 17'd423;    6'd25: return 17'd335;
      6'd26: return 17'd272;    6'd27: return 17'd215;
      6'd28: return 17'd172;    6'd29: return 17'd137;
      6'd30: return 17'd110;    6'd31: return 17'd87;
      6'd32: return 17'd70;     6'd33: return 17'd56;
      6'd34: return 17'd45;     6'd35: return 17'd36;
      6'd36: return 17'd29;     6'd37: return 17'd23;
      6'd38: return 17'd18;     6'd39: return 17'd15;
      default: return 17'd1024;
    endcase
  endfunction

endpackage

FILE: hw/rtl/fair_share_vruntime_scheduler_unit.sv
// ----------------------------------------------------------------------------
// fair_share_vruntime_scheduler_unit
// Virtual-runtime run queue with a process table of one read and one write
// port and one shared restoring divider.
// ----------------------------------------------------------------------------
// One command is worked at a time; in_stall is high until the sequencer is
// back in idle, which it reaches as its item enters the output register.
// Enqueue and dequeue read the entry, update it and report. Tick reads the
// entry, adds the charge divided by its weight, writes it back, scans for
// the least virtual runtime and reports. Pick scans for the queued entry
// with the least vruntime, divides for its slice, writes it and reports; an
// empty queue skips divide and write, a zero weight total only the divide.
// The minimum search uses the single read port and the divider resolves one
// quotient bit per cycle. A result held by out_stall keeps the sequencer in
// its done state. After reset a clearing pass zeroes the table before any item.
`timescale 1ns / 1ps
module fair_share_vruntime_scheduler_unit
  import fsvs_pkg::*;
#(
  parameter int PROC_SLOTS = PROC_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         proc_slot,
  input  logic signed [5:0]  nice_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [5:0]         chosen_slot,
  output logic [15:0]        slice_left,
  output logic               resched,
  output logic [63:0]        slot_vruntime
);

  localparam int AW = $clog2(PROC_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(PROC_SLOTS - 1);

  entry_t mem [PROC_SLOTS];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  state_t state, state_next;
  logic [15:0] max_slice;
  logic [22:0] weight_sum;
  logic [63:0] least_vr;
  logic [1:0] cmd;
  logic [5:0] slot;
  logic signed [5:0] nice;
  logic [AW-1:0] idx;
  logic found;
  logic [AW-1:0] best_idx;
  entry_t best;
  entry_t cur;

  logic [33:0] div_num;
  logic [22:0] div_den;
  logic [22:0] div_rem;
  logic [33:0] div_quo;
  logic [5:0] div_cnt;

  logic [1:0] res_status;
  logic [5:0] res_slot;
  logic [15:0] res_slice;
  logic res_resched;
  logic [63:0] res_vr;

  logic [15:0] slot_wide;
  logic [AW-1:0] slot_addr;
  logic [16:0] cur_weight;
  logic [23:0] ws_add;
  logic [23:0] div_t;
  logic div_ge;
  logic [23:0] div_diff;
  logic take;
  entry_t enq_entry;
  logic [63:0] tick_vr;
  logic [15:0] tick_slice;
  logic [15:0] pick_slice;
  logic out_free;

  assign slot_wide = {10'b0, slot};
  assign slot_addr = slot_wide[AW-1:0];
  assign cur_weight = weight_of(rd_data.nice);
  assign ws_add = {1'b0, weight_sum} + {7'b0, weight_of(nice)};
  assign out_free = !out_valid || !out_stall;

  assign div_t = {div_rem, div_num[33]};
  assign div_ge = div_t >= {1'b0, div_den};
  assign div_diff = div_t - {1'b0, div_den};

  assign take = (rd_data.queued || (cmd == CMD_TICK && idx == slot_addr)) &&
                (!found || rd_data.vr < best.vr);

  always_comb begin
    enq_entry.queued = 1'b1;
    enq_entry.nice = nice;
    enq_entry.vr = (rd_data.vr < least_vr) ? least_vr : rd_data.vr;
    enq_entry.slice = (rd_data.slice == 16'd0 || rd_data.slice > max_slice) ?
                      max_slice : rd_data.slice;
  end

  assign tick_vr = cur.vr + 64'(div_quo);
  assign tick_slice = (cur.slice == 16'd0) ? 16'd0 : cur.slice - 16'd1;

  always_comb begin
    if (weight_sum == 23'd0) pick_slice = max_slice;
    else if (div_quo == 34'd0) pick_slice = 16'd1;
    else if (div_quo > 34'd65535) pick_slice = 16'hFFFF;
    else pick_slice = div_quo[15:0];
  end

  // table storage
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (idx == LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_PICK) state_next = S_SCAN_RD;
          else if ({10'b0, proc_slot} < 16'(PROC_SLOTS)) state_next = S_READ;
          else state_next = S_DONE;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = (cmd == CMD_TICK) ? S_DIV : S_DONE;
      S_DIV: begin
        if (div_cnt == 6'd33) state_next = (cmd == CMD_TICK) ? S_TICK_WR : S_PICK_WR;
      end
      S_TICK_WR: state_next = S_SCAN_RD;
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: state_next = (idx == LAST) ? S_SCAN_END : S_SCAN_RD;
      S_SCAN_END: begin
        if (cmd == CMD_TICK || !found) state_next = S_DONE;
        else if (weight_sum == 23'd0) state_next = S_PICK_WR;
        else state_next = S_DIV;
      end
      S_PICK_WR: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs of the sequencer: handshake, table ports
  always_comb begin
    in_stall = (state != S_IDLE);
    rd_addr = idx;
    mem_we = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = rd_data;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = idx;
        mem_wdata = '0;
      end
      S_READ: rd_addr = slot_addr;
      S_EXEC: begin
        if (cmd == CMD_ENQ && !rd_data.queued) begin
          mem_we = 1'b1;
          mem_wdata = enq_entry;
        end else if (cmd == CMD_DEQ && rd_data.queued) begin
          mem_we = 1'b1;
          mem_wdata.queued = 1'b0;
        end
      end
      S_TICK_WR: begin
        mem_we = 1'b1;
        mem_wdata = cur;
        mem_wdata.vr = tick_vr;
        mem_wdata.slice = tick_slice;
      end
      S_PICK_WR: begin
        mem_we = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = best;
        mem_wdata.slice = pick_slice;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      out_valid <= 1'b0;
      max_slice <= MAX_SLICE_RST;
      weight_sum <= '0;
      least_vr <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) max_slice <= cfg_data;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: idx <= idx + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            slot <= proc_slot;
            nice <= clamp_nice(nice_value);
            idx <= '0;
            found <= 1'b0;
            res_status <= STATUS_IGNORED;
            res_slot <= proc_slot;
            res_slice <= '0;
            res_resched <= 1'b0;
            res_vr <= '0;
          end
        end
        S_EXEC: begin
          cur <= rd_data;
          case (cmd)
            CMD_ENQ: begin
              if (!rd_data.queued) begin
                weight_sum <= ws_add[23] ? WEIGHT_SUM_MAX : ws_add[22:0];
                res_status <= STATUS_OK;
                res_slice <= enq_entry.slice;
                res_vr <= enq_entry.vr;
              end
            end
            CMD_DEQ: begin
              if (rd_data.queued) begin
                // saturate at zero
                weight_sum <= (weight_sum >= {6'b0, cur_weight}) ?
                              weight_sum - {6'b0, cur_weight} : 23'd0;
                res_status <= STATUS_OK;
                res_slice <= rd_data.slice;
                res_vr <= rd_data.vr;
              end
            end
            default: begin
              div_num <= CHARGE_BASE;
              div_den <= {6'b0, cur_weight};
              div_rem <= '0;
              div_cnt <= '0;
            end
          endcase
        end
        S_DIV: begin
          div_rem <= div_ge ? div_diff[22:0] : div_t[22:0];
          div_quo <= {div_quo[32:0], div_ge};
          div_num <= {div_num[32:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
        end
        S_TICK_WR: begin
          res_status <= STATUS_OK;
          res_slice <= tick_slice;
          res_resched <= (tick_slice == 16'd0);
          res_vr <= tick_vr;
        end
        S_SCAN_CMP: begin
          if (take) begin
            found <= 1'b1;
            best_idx <= idx;
            best <= rd_data;
          end
          idx <= idx + 1'b1;
        end
        S_SCAN_END: begin
          if (cmd == CMD_TICK) begin
            least_vr <= best.vr;
          end else if (found) begin
            div_num <= 34'(max_slice) * 34'(weight_of(best.nice));
            div_den <= weight_sum;
            div_rem <= '0;
            div_cnt <= '0;
          end else begin
            res_status <= STATUS_EMPTY;
            res_slot <= '0;
          end
        end
        S_PICK_WR: begin
          res_status <= STATUS_OK;
          res_slot <= 6'(best_idx);
          res_slice <= pick_slice;
          res_vr <= best.vr;
        end
        S_DONE: begin
          if (out_free) begin
            status <= res_status;
            chosen_slot <= res_slot;
            slice_left <= res_slice;
            resched <= res_resched;
            slot_vruntime <= res_vr;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/fsvs_checker.sv
// ----------------------------------------------------------------------------
// fsvs_checker
// Port-level checks on the result channel of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fair_share_vruntime_scheduler_unit_defines.svh"
module fsvs_checker
  import fsvs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [5:0]         chosen_slot,
  input logic [15:0]        slice_left,
  input logic               resched,
  input logic [63:0]        slot_vruntime
);

  logic empty_fields_zero;
  logic ignored_fields_zero;
  logic resched_fields_ok;

  assign empty_fields_zero = chosen_slot == 6'd0 && slice_left == 16'd0 &&
                             slot_vruntime == 64'd0;
  assign ignored_fields_zero = slice_left == 16'd0 && !resched && slot_vruntime == 64'd0;
  assign resched_fields_ok = slice_left == 16'd0 && status == STATUS_OK;

  // hold a stalled item
  `FSVS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
  `FSVS_ASSERT_IMPL(a_empty, out_valid && status == STATUS_EMPTY, empty_fields_zero)
  `FSVS_ASSERT_IMPL(a_ignored, out_valid && status == STATUS_IGNORED, ignored_fields_zero)
  `FSVS_ASSERT_IMPL(a_resched, out_valid && resched, resched_fields_ok)

endmodule

bind fair_share_vruntime_scheduler_unit fsvs_checker u_fsvs_checker (.*);
